// ----- rtl/lapc_pkg.sv -----
// Package for the linear actuator position controller.
// Types, constants and command/status structs shared by all modules. No dependencies.
`default_nettype none
package lapc_pkg;
   localparam int unsigned LostTimeoutUs = 200000;
   localparam int unsigned MinStepUs     = 1000;
   localparam int unsigned SlewQ8        = 419;
   localparam int unsigned ArriveUm      = 1000;

   localparam logic [23:0] TIMER_MAX     = 24'hFFFFFF;
   localparam logic [15:0] LIMIT_DEFAULT = 16'd31130;
   localparam logic [15:0] LIMIT_MAX     = 16'd32112;

   localparam logic [1:0] OP_MEASURE = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_MOVE    = 2'd2;
   localparam logic [1:0] OP_STOP    = 2'd3;

   localparam logic [2:0] CSR_RAW_MIN   = 3'd0;
   localparam logic [2:0] CSR_RAW_MAX   = 3'd1;
   localparam logic [2:0] CSR_STROKE    = 3'd2;
   localparam logic [2:0] CSR_KP        = 3'd3;
   localparam logic [2:0] CSR_MIN_PWM   = 3'd4;
   localparam logic [2:0] CSR_SAFE_PWM  = 3'd5;
   localparam logic [2:0] CSR_SAFE_AREA = 3'd6;
   localparam logic [2:0] CSR_EMER_AREA = 3'd7;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_EMERG   = 2'd2;
   localparam logic [1:0] ST_SAFE    = 2'd3;

   localparam int DivSteps = 18;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] raw_position;
      logic [15:0] elapsed_us;
      logic [17:0] target_um;
      logic signed [15:0] power_q15;
   } req_type;

   typedef struct packed {
      logic        dir_a;
      logic        dir_b;
      logic [14:0] duty;
      logic [1:0]  status;
      logic [17:0] position_um;
   } rsp_type;

   typedef struct packed {
      logic load;      // latch request, start work
      logic div_step;  // one restoring division step
      logic mul;       // product stage: divider preload and tick products
      logic finish;    // commit state and form result
   } cmd_type;

   typedef struct packed {
      logic need_div;  // measurement inside raw range
   } sts_type;
endpackage
`default_nettype wire

// ----- rtl/lapc_if.sv -----
// Valid/ready channel interface carrying one payload.
// Depends on lapc_pkg for payload types.
`default_nettype none
interface lapc_req_if;
   import lapc_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lapc_rsp_if;
   import lapc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/lapc_ctrl.sv -----
// Sequencer for the controller: load, product, optional serial divide, finish.
// Depends on lapc_pkg.
`default_nettype none
module lapc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_fire,
   input  wire logic              rsp_free,
   input  wire lapc_pkg::sts_type sts,
   output lapc_pkg::cmd_type      cmd,
   output logic                   busy
);
   import lapc_pkg::*;
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_MUL  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
               cnt_in   = '0;
            end
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = sts.need_div ? S_DIV : S_FIN;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DivSteps - 1)) state_in = S_FIN;
         end
         S_FIN: begin
            if (rsp_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/lapc_dp.sv -----
// Datapath: configuration, controller state, serial divider and control law.
// Depends on lapc_pkg; driven by lapc_ctrl commands.
`default_nettype none
module lapc_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic [2:0]        csr_index,
   input  wire logic [17:0]       csr_data,
   input  wire lapc_pkg::req_type req_data,
   input  wire lapc_pkg::cmd_type cmd,
   output lapc_pkg::sts_type      sts,
   output lapc_pkg::rsp_type      result
);
   import lapc_pkg::*;

   logic [15:0] raw_min_ff, raw_max_ff, kp_ff;
   logic [17:0] stroke_ff, safe_area_ff, emer_area_ff;
   logic [14:0] min_pwm_ff, safe_pwm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_min_ff   <= 16'd0;
         raw_max_ff   <= 16'd1023;
         stroke_ff    <= 18'd200000;
         kp_ff        <= 16'd419;
         min_pwm_ff   <= 15'd3277;
         safe_pwm_ff  <= 15'd16384;
         safe_area_ff <= 18'd30000;
         emer_area_ff <= 18'd10000;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RAW_MIN:   raw_min_ff   <= csr_data[15:0];
            CSR_RAW_MAX:   raw_max_ff   <= csr_data[15:0];
            CSR_STROKE:    stroke_ff    <= csr_data;
            CSR_KP:        kp_ff        <= csr_data[15:0];
            CSR_MIN_PWM:   min_pwm_ff   <= csr_data[14:0];
            CSR_SAFE_PWM:  safe_pwm_ff  <= csr_data[14:0];
            CSR_SAFE_AREA: safe_area_ff <= csr_data;
            CSR_EMER_AREA: emer_area_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // controller state
   logic [17:0] meas_ff, goal_ff;
   logic        mvalid_ff;
   logic signed [16:0] wanted_ff, present_ff;
   logic [15:0] limit_ff;
   logic [23:0] tmeas_ff, tstep_ff;
   logic [1:0]  hstat_ff;
   logic        ha_ff, hb_ff;
   logic [14:0] hduty_ff;

   // latched request and work registers
   req_type     req_ff;
   logic [23:0] tm_ff, ts_ff;       // timers after adding elapsed
   logic [33:0] num_ff;             // low 18 product bits, shifted out by the divider
   logic [15:0] den_ff;
   logic [16:0] rem_ff;
   logic [17:0] quo_ff;
   logic [17:0] mag_ff;             // |err|
   logic        neg_ff;             // err < 0
   logic [33:0] prod_ff;            // kp*|err|
   logic [17:0] step_ff;            // slew step, saturated

   logic [24:0] tm_sum, ts_sum;
   logic [16:0] raw_off;
   logic        in_range;
   logic [33:0] num_full, step_full;
   assign tm_sum  = {1'b0, tmeas_ff} + {9'd0, req_data.elapsed_us};
   assign ts_sum  = {1'b0, tstep_ff} + {9'd0, req_data.elapsed_us};
   assign in_range = (req_ff.raw_position > raw_min_ff) && (req_ff.raw_position < raw_max_ff);
   assign raw_off = {1'b0, req_ff.raw_position} - {1'b0, raw_min_ff};
   assign sts.need_div = (req_ff.opcode == OP_MEASURE) && in_range;
   assign num_full  = {16'd0, stroke_ff} * {18'd0, raw_off[15:0]};
   assign step_full = {10'd0, ts_ff} * 34'(SlewQ8);

   // restoring divider step; quotient fits 18 bits, so the top 16 bits preload the remainder
   logic [17:0] rem_sh;
   logic        fits;
   assign rem_sh = {rem_ff, num_ff[33]};
   assign fits   = rem_sh >= {2'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         tm_ff  <= tm_sum[24] ? TIMER_MAX : tm_sum[23:0];
         ts_ff  <= ts_sum[24] ? TIMER_MAX : ts_sum[23:0];
         if (goal_ff >= meas_ff) begin
            mag_ff <= goal_ff - meas_ff;
            neg_ff <= 1'b0;
         end else begin
            mag_ff <= meas_ff - goal_ff;
            neg_ff <= 1'b1;
         end
      end
      if (cmd.mul) begin
         num_ff  <= {num_full[17:0], 16'd0};
         den_ff  <= raw_max_ff - raw_min_ff;
         rem_ff  <= {1'b0, num_full[33:18]};
         prod_ff <= {16'd0, mag_ff} * {18'd0, kp_ff};
         // duty gap never exceeds 2^17, so a saturated step is exact
         step_ff <= (step_full[33:8] > 26'h1FFFF) ? 18'h1FFFF : step_full[25:8];
      end
      if (cmd.div_step) begin
         num_ff <= {num_ff[32:0], 1'b0};
         rem_ff <= fits ? 17'(rem_sh - {2'b0, den_ff}) : rem_sh[16:0];
         quo_ff <= {quo_ff[16:0], fits};
      end
   end

   // tick evaluation, from registered products
   logic signed [17:0] w, w_lim, p, spwm, stp;
   logic [25:0] kmag;
   logic [17:0] mag2;
   logic        lost, early, idle_brake, emerg;
   logic [1:0]  t_stat;
   logic signed [17:0] pnext;
   always_comb begin
      spwm     = {3'b0, safe_pwm_ff};
      stp      = step_ff;
      kmag     = prod_ff[33:8];
      mag2     = '0;
      lost     = !mvalid_ff || (tm_ff > 24'(LostTimeoutUs));
      early    = ts_ff < 24'(MinStepUs);
      idle_brake = (present_ff == 0) && (wanted_ff == 0);
      if (mag_ff < 18'(ArriveUm)) w = '0;
      else begin
         if (kmag < {11'd0, min_pwm_ff}) mag2 = {3'd0, min_pwm_ff};
         else if (kmag > 26'(limit_ff)) mag2 = {2'b0, limit_ff};
         else mag2 = kmag[17:0];
         if (mag2 > {2'b0, limit_ff}) mag2 = {2'b0, limit_ff};
         w = neg_ff ? -$signed(mag2) : $signed(mag2);
      end
      w_lim = w;
      emerg = ({1'b0, meas_ff} < {1'b0, emer_area_ff} && w < 0) ||
              ($signed({1'b0, meas_ff}) > $signed({1'b0, stroke_ff} - {1'b0, emer_area_ff})
               && w > 0);
      t_stat = ST_OK;
      if ({1'b0, meas_ff} < {1'b0, safe_area_ff} && w < 0) begin
         t_stat = ST_SAFE;
         if (w < -spwm) w = -spwm;
      end
      if ($signed({1'b0, meas_ff}) > $signed({1'b0, stroke_ff} - {1'b0, safe_area_ff})
          && w > 0) begin
         t_stat = ST_SAFE;
         if (w > spwm) w = spwm;
      end
      p = 18'(present_ff);
      if (p > w) begin
         pnext = p - stp;
         if (pnext < w || (p - w) <= stp) pnext = w;
      end else begin
         pnext = p + stp;
         if (pnext > w || (w - p) <= stp) pnext = w;
      end
   end

   logic [15:0] newlim;
   assign newlim = req_ff.power_q15[15] ? LIMIT_DEFAULT :
                   (req_ff.power_q15 > $signed(LIMIT_MAX)) ? LIMIT_MAX : req_ff.power_q15;

   logic [17:0] mnew;
   always_comb begin
      if (req_ff.raw_position <= raw_min_ff) mnew = '0;
      else if (req_ff.raw_position >= raw_max_ff) mnew = stroke_ff;
      else mnew = quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meas_ff <= '0; goal_ff <= '0; mvalid_ff <= 1'b0;
         wanted_ff <= '0; present_ff <= '0; limit_ff <= LIMIT_MAX;
         tmeas_ff <= '0; tstep_ff <= '0; hstat_ff <= ST_OK;
         ha_ff <= 1'b0; hb_ff <= 1'b0; hduty_ff <= '0;
      end else if (cmd.finish) begin
         tmeas_ff <= tm_ff;
         tstep_ff <= ts_ff;
         case (req_ff.opcode)
            OP_MEASURE: begin
               meas_ff <= mnew; mvalid_ff <= 1'b1; tmeas_ff <= '0;
            end
            OP_MOVE: begin
               limit_ff <= newlim;
               goal_ff  <= (req_ff.target_um > stroke_ff) ? stroke_ff : req_ff.target_um;
               if (!mvalid_ff || ((req_ff.target_um > stroke_ff) ? stroke_ff
                                  : req_ff.target_um) > meas_ff)
                  wanted_ff <= 17'(newlim);
               else
                  wanted_ff <= -$signed(17'(newlim));
            end
            OP_STOP: begin
               wanted_ff <= '0; present_ff <= '0; goal_ff <= meas_ff;
               ha_ff <= 1'b0; hb_ff <= 1'b0; hduty_ff <= '0;
            end
            OP_TICK: begin
               hstat_ff <= ST_OK;
               if (lost) begin
                  hstat_ff <= ST_MISSING; present_ff <= '0;
                  ha_ff <= 1'b1; hb_ff <= 1'b1; hduty_ff <= '0;
               end else if (!early) begin
                  tstep_ff <= '0;
                  if (idle_brake) begin
                     ha_ff <= 1'b1; hb_ff <= 1'b1; hduty_ff <= '0;
                  end else if (emerg) begin
                     hstat_ff <= ST_EMERG; present_ff <= '0;
                     wanted_ff <= 17'(w_lim);
                     ha_ff <= 1'b1; hb_ff <= 1'b1; hduty_ff <= '0;
                  end else begin
                     hstat_ff <= t_stat;
                     wanted_ff <= 17'(w);
                     present_ff <= 17'(pnext);
                     if (pnext > 0) begin
                        ha_ff <= 1'b0; hb_ff <= 1'b1; hduty_ff <= pnext[14:0];
                     end else begin
                        ha_ff <= 1'b1; hb_ff <= 1'b0; hduty_ff <= 15'(-pnext);
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign result.dir_a       = ha_ff;
   assign result.dir_b       = hb_ff;
   assign result.duty        = hduty_ff;
   assign result.status      = hstat_ff;
   assign result.position_um = mvalid_ff ? meas_ff : '0;
endmodule
`default_nettype wire

// ----- rtl/linear_actuator_position_controller.sv -----
// Linear actuator position controller.
// Requests arrive on req (valid/ready); one response per request leaves on rsp.
// Opcodes: measurement, tick, move, stop. Configuration via csr_write/index/data,
// written only while idle. The block itself does not enforce this. A measurement
// strictly inside the raw calibration range also runs the serial restoring divider
// before its finish step. One request is in work at a time; the next
// can be accepted at the edge that loads the response into the output register.
// If the receiver stalls, the finished response stays in the output register and
// a new request still runs up to its commit step, which waits for the register
// to free. Reset (synchronous, active high) restores register defaults, clears
// position, timers and drive, empties the output register and holds req.ready low.
`default_nettype none
module linear_actuator_position_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   lapc_req_if.sink         req,
   lapc_rsp_if.source       rsp,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [17:0] csr_data
);
   import lapc_pkg::*;
   cmd_type cmd;
   sts_type sts;
   rsp_type result;
   logic    busy, req_fire, rsp_free;
   logic    ovalid_ff;
   rsp_type odata_ff;

   assign req.ready = !busy && !reset;
   assign req_fire  = req.valid && !busy && !reset;
   assign rsp_free  = !ovalid_ff || rsp.ready;

   lapc_ctrl u_ctrl (.clock, .reset, .req_fire, .rsp_free, .sts, .cmd, .busy);
   lapc_dp u_dp (.clock, .reset, .csr_write, .csr_index, .csr_data,
                 .req_data(req.data), .cmd, .sts, .result);

   // finish commits state at this edge; result is read back next cycle
   logic pend_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.finish;
         if (pend_ff) ovalid_ff <= 1'b1;
         else if (rsp.ready) ovalid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (pend_ff) odata_ff <= result;
   end

   assign rsp.valid = ovalid_ff;
   assign rsp.data  = odata_ff;
endmodule
`default_nettype wire
